FILE: hdl/pac_pkg.sv
// Shared types and constants for the pixel alpha compositor.
// No dependencies; every other file of the block refers to this package by scoped names.
package pac_pkg;

    // Pixel channel width and the full-scale channel value.
    localparam int unsigned PIX_W = 8;
    localparam logic [PIX_W-1:0] PIX_FULL = 8'hFF;

    // Number of register stages in one lane, output register included.
    localparam int unsigned NSTG = 6;

    // floor(2^32 / 255); a product with it, shifted down by 32, underestimates x/255 by at most one.
    localparam logic [31:0] DIV255_RECIP = 32'h0101_0101;

    // Configuration port.
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic REG_BLEND_MODE = 1'b0;   // word index of the blend mode register

    // Blend modes.
    localparam logic MODE_OVER = 1'b0;
    localparam logic MODE_FLAT = 1'b1;

    // Stage load enables handed from the pipeline control to the lanes.
    typedef struct packed {
        logic [NSTG-1:0] load;
    } t_pipe_ctl;

    // Stage occupancy reported by the pipeline control.
    typedef struct packed {
        logic [NSTG-1:0] vld;
    } t_pipe_sts;

endpackage

FILE: hdl/pac_if.sv
// Valid/ready stream interfaces for the pixel alpha compositor input and output.
// Depends on pac_pkg for the channel width.
interface pac_in_if;
    logic                      valid;
    logic                      ready;
    logic [pac_pkg::PIX_W-1:0] dst_c0;
    logic [pac_pkg::PIX_W-1:0] dst_c1;
    logic [pac_pkg::PIX_W-1:0] dst_c2;
    logic [pac_pkg::PIX_W-1:0] dst_alpha;
    logic [pac_pkg::PIX_W-1:0] src_c0;
    logic [pac_pkg::PIX_W-1:0] src_c1;
    logic [pac_pkg::PIX_W-1:0] src_c2;
    logic [pac_pkg::PIX_W-1:0] src_alpha;

    modport source (
        output valid, dst_c0, dst_c1, dst_c2, dst_alpha, src_c0, src_c1, src_c2, src_alpha,
        input  ready
    );
    modport sink (
        input  valid, dst_c0, dst_c1, dst_c2, dst_alpha, src_c0, src_c1, src_c2, src_alpha,
        output ready
    );
endinterface

interface pac_out_if;
    logic                      valid;
    logic                      ready;
    logic [pac_pkg::PIX_W-1:0] out_c0;
    logic [pac_pkg::PIX_W-1:0] out_c1;
    logic [pac_pkg::PIX_W-1:0] out_c2;
    logic [pac_pkg::PIX_W-1:0] out_alpha;

    modport source (
        output valid, out_c0, out_c1, out_c2, out_alpha,
        input  ready
    );
    modport sink (
        input  valid, out_c0, out_c1, out_c2, out_alpha,
        output ready
    );
endinterface

FILE: hdl/pac_cfg.sv
// APB-style configuration register file holding the blend mode.
// Depends on pac_pkg for address/data widths, register index and mode codes.
module pac_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pac_pkg::PADDR_W-1:0] paddr,
    input  logic [pac_pkg::PDATA_W-1:0] pwdata,
    output logic [pac_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic                        o_mode
);

    logic r_mode;
    logic n_mode;

    // The port never inserts wait states.
    assign pready = 1'b1;

    // Write decode: the register is updated in the access phase of a write.
    always_comb begin
        n_mode = r_mode;
        if (psel && penable && pwrite && (paddr[2] == pac_pkg::REG_BLEND_MODE)) begin
            n_mode = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= pac_pkg::MODE_OVER;
        end else begin
            r_mode <= n_mode;
        end
    end

    // Read mux: unmapped words read as zero.
    always_comb begin
        prdata = '0;
        if (paddr[2] == pac_pkg::REG_BLEND_MODE) begin
            prdata = {{(pac_pkg::PDATA_W-1){1'b0}}, r_mode};
        end
    end

    assign o_mode = r_mode;

endmodule

FILE: hdl/pac_ctrl.sv
// Valid tracking and per-stage ready chain for the compositor pipeline.
// Depends on pac_pkg for the stage count and the control/status structs.
module pac_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output pac_pkg::t_pipe_ctl o_ctl,
    output pac_pkg::t_pipe_sts o_sts
);

    localparam int unsigned N = pac_pkg::NSTG;

    logic [N-1:0] r_vld;
    logic [N-1:0] n_vld;
    logic [N-1:0] stg_ready;
    logic [N-1:0] up_vld;

    // A stage can take new data when it is empty or its content moves on this cycle.
    always_comb begin
        stg_ready[N-1] = !r_vld[N-1] || i_out_ready;
        for (int k = N - 2; k >= 0; k--) begin
            stg_ready[k] = !r_vld[k] || stg_ready[k+1];
        end
    end

    // Valid bit offered to each stage from the one before it.
    assign up_vld = {r_vld[N-2:0], i_in_valid};

    // Valid bits advance with their data; a stalled stage keeps its bit.
    always_comb begin
        for (int k = 0; k < N; k++) begin
            n_vld[k] = stg_ready[k] ? up_vld[k] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Payload registers load only when a valid item moves in.
    assign o_ctl.load  = stg_ready & up_vld;
    assign o_sts.vld   = r_vld;
    assign o_in_ready  = stg_ready[0];
    assign o_out_valid = r_vld[N-1];

endmodule

FILE: hdl/pac_lane.sv
// One channel lane of the compositor: blend numerator, then two exact divides by 255.
// Depends on pac_pkg for widths, constants and the stage control struct.
module pac_lane (
    input  logic                      i_clk,
    input  pac_pkg::t_pipe_ctl        i_ctl,
    input  logic                      i_mode,
    input  logic                      i_off_en,
    input  logic [pac_pkg::PIX_W-1:0] i_d,
    input  logic [pac_pkg::PIX_W-1:0] i_s,
    input  logic [pac_pkg::PIX_W-1:0] i_ad,
    input  logic [pac_pkg::PIX_W-1:0] i_as,
    output logic [pac_pkg::PIX_W-1:0] o_res
);

    // Stage 0: the two 8x8 products and the flatten offset.
    logic [15:0] r_pa;
    logic [15:0] r_pb;
    logic [7:0]  r_s0;
    logic        r_mode0;
    logic [7:0]  r_off0;
    logic [7:0]  n_inv;
    logic [7:0]  n_off;

    assign n_inv = pac_pkg::PIX_FULL - i_ad;
    assign n_off = (i_off_en && (i_mode == pac_pkg::MODE_FLAT)) ? n_inv : 8'd0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_pa    <= {8'd0, i_ad} * {8'd0, i_d};
            r_pb    <= {8'd0, n_inv} * {8'd0, i_as};
            r_s0    <= i_s;
            r_mode0 <= i_mode;
            r_off0  <= n_off;
        end
    end

    // Stage 1: numerator Ad*d*255 plus the source term in over mode.
    logic [23:0] r_num;
    logic [7:0]  r_off1;
    logic [23:0] n_dst_term;
    logic [23:0] n_src_term;

    assign n_dst_term = {r_pa, 8'd0} - {8'd0, r_pa};
    assign n_src_term = (r_mode0 == pac_pkg::MODE_OVER) ? ({8'd0, r_pb} * {16'd0, r_s0}) : 24'd0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r_num  <= n_dst_term + n_src_term;
            r_off1 <= r_off0;
        end
    end

    // Stage 2: reciprocal estimate of the first divide by 255.
    logic [23:0] r_x;
    logic [15:0] r_q1;
    logic [7:0]  r_off2;
    logic [55:0] n_prod1;

    assign n_prod1 = {32'd0, r_num} * {24'd0, pac_pkg::DIV255_RECIP};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r_x    <= r_num;
            r_q1   <= n_prod1[47:32];
            r_off2 <= r_off1;
        end
    end

    // Stage 3: correct the estimate, which is low by at most one.
    logic [15:0] r_d1;
    logic [7:0]  r_off3;
    logic [23:0] n_rem1;

    assign n_rem1 = r_x - ({r_q1, 8'd0} - {8'd0, r_q1});

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r_d1   <= r_q1 + {15'd0, (n_rem1 >= 24'd255)};
            r_off3 <= r_off2;
        end
    end

    // Stage 4: reciprocal estimate of the second divide by 255.
    logic [15:0] r_y;
    logic [7:0]  r_q2;
    logic [7:0]  r_off4;
    logic [47:0] n_prod2;

    assign n_prod2 = {32'd0, r_d1} * {16'd0, pac_pkg::DIV255_RECIP};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r_y    <= r_d1;
            r_q2   <= n_prod2[39:32];
            r_off4 <= r_off3;
        end
    end

    // Stage 5 (output register): correct, then add the white background offset.
    logic [7:0]  r_res;
    logic [15:0] n_rem2;
    logic [7:0]  n_res;

    assign n_rem2 = r_y - ({r_q2, 8'd0} - {8'd0, r_q2});
    assign n_res  = r_q2 + {7'd0, (n_rem2 >= 16'd255)} + r_off4;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[5]) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

FILE: hdl/pixel_alpha_composite_top.sv
// Top level of the pixel alpha compositor: configuration port, pipeline control, four lanes.
// Depends on pac_pkg, pac_if, pac_cfg, pac_ctrl and pac_lane.

// The compositor takes one destination/source pixel pair per clock while the output is ready,
// passing it through the six register stages of each lane (products, numerator, then an
// estimate and a correction for each of the two divides by 255, the last correction in the
// output register). The blend mode register at byte address 0 selects the over blend (0) or
// flattening of the destination onto white (1); write it only while no pixel is in flight.
// Alpha is computed by the same lane as the colors with both channel values held at full
// scale.
module pixel_alpha_composite_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pac_pkg::PADDR_W-1:0] paddr,
    input  logic [pac_pkg::PDATA_W-1:0] pwdata,
    output logic [pac_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    pac_in_if.sink                      i_pix,
    pac_out_if.source                   o_pix
);

    logic               mode;
    pac_pkg::t_pipe_ctl ctl;
    pac_pkg::t_pipe_sts sts;

    // Configuration registers.
    pac_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mode  (mode)
    );

    // Pipeline valid bits and stall handling.
    pac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .i_out_ready (o_pix.ready),
        .o_in_ready  (i_pix.ready),
        .o_out_valid (o_pix.valid),
        .o_ctl       (ctl),
        .o_sts       (sts)
    );

    // Color lanes.
    pac_lane u_lane_c0 (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_mode   (mode),
        .i_off_en (1'b1),
        .i_d      (i_pix.dst_c0),
        .i_s      (i_pix.src_c0),
        .i_ad     (i_pix.dst_alpha),
        .i_as     (i_pix.src_alpha),
        .o_res    (o_pix.out_c0)
    );

    pac_lane u_lane_c1 (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_mode   (mode),
        .i_off_en (1'b1),
        .i_d      (i_pix.dst_c1),
        .i_s      (i_pix.src_c1),
        .i_ad     (i_pix.dst_alpha),
        .i_as     (i_pix.src_alpha),
        .o_res    (o_pix.out_c1)
    );

    pac_lane u_lane_c2 (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_mode   (mode),
        .i_off_en (1'b1),
        .i_d      (i_pix.dst_c2),
        .i_s      (i_pix.src_c2),
        .i_ad     (i_pix.dst_alpha),
        .i_as     (i_pix.src_alpha),
        .o_res    (o_pix.out_c2)
    );

    // Alpha lane: full-scale channel values give the over rule for alpha and pass-through
    // of the destination alpha when flattening.
    pac_lane u_lane_alpha (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_mode   (mode),
        .i_off_en (1'b0),
        .i_d      (pac_pkg::PIX_FULL),
        .i_s      (pac_pkg::PIX_FULL),
        .i_ad     (i_pix.dst_alpha),
        .i_as     (i_pix.src_alpha),
        .o_res    (o_pix.out_alpha)
    );

    // An empty pipeline always accepts a pixel.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sts.vld == '0) |-> i_pix.ready)
        else $error("empty pipeline refused an input transfer");

    // An input transfer occupies the first stage on the next cycle.
    a_enter_stage0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> sts.vld[0])
        else $error("accepted pixel did not enter the first stage");

    // An output transfer with nothing behind it empties the output register.
    a_drain_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.ready && !sts.vld[pac_pkg::NSTG-2]) |=> !o_pix.valid)
        else $error("output stayed valid after its transfer with no follower");

endmodule
